FILE: rtl/moving_average_auto_gain_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average gain core
// Assertions are compiled in unless SYNTH is defined; with SYNTH they are empty.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_AUTO_GAIN_CORE_ASSERT_SVH
`define MOVING_AVERAGE_AUTO_GAIN_CORE_ASSERT_SVH
`ifndef SYNTH
// plain property, checked at every clock edge outside reset
`define MAGC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// same-cycle implication
`define MAGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MAGC_ASSERT(lbl, clk, rstn, prop, msg)
`define MAGC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants, types and register map of the moving-average gain core.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int WARMUP_COUNT  = 100;

  // widest ring address that the depth range needs
  localparam int RING_AW_MAX = 16;

  localparam logic [14:0] OUT_CLAMP = 15'd25600;
  localparam logic [31:0] GAIN_ONE  = 32'h0001_0000;

  localparam logic [15:0] GAIN_TARGET_RST     = 16'd12800;
  localparam logic [15:0] LEVEL_THRESHOLD_RST = 16'd256;
  localparam logic [10:0] HISTORY_LEN_RST     = 11'd1024;

  // register word index within the apb window
  typedef enum logic [1:0] {
    REG_GAIN_TARGET     = 2'd0,
    REG_LEVEL_THRESHOLD = 2'd1,
    REG_HISTORY_LEN     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [RING_AW_MAX-1:0] addr;
    logic [15:0]            wr_data;
  } ring_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/moving_average_auto_gain_core.sv
// ----------------------------------------------------------------------------
// moving_average_auto_gain_core
// Moving-average automatic gain control: scales each Q8.8 level sample by a
// Q16.16 gain derived from the mean of recent at-or-above-threshold samples.
// ----------------------------------------------------------------------------
// One item at a time. A sample below the threshold passes the multiply and
// output states after acceptance. A stored sample passes the ring state
// first, then the numerator state if it triggers a gain update; an update
// that meets a zero sum goes on to the multiply. A gain update otherwise
// adds the multiply for target times entries and a bit-serial divide of
// 32 + clog2(HISTORY_DEPTH + 1) quotient bits, in the divider start and wait
// states. The next item can be accepted from the cycle in which the result is
// offered. The history memory needs no clearing pass after reset: a high-water
// mark makes unwritten entries read as zero. A finished result waits in the
// output register while the next item is accepted.
`include "moving_average_auto_gain_core_assert.svh"

module moving_average_auto_gain_core #(
  parameter int HISTORY_DEPTH = mavg_pkg::HISTORY_DEPTH,
  parameter int WARMUP_COUNT  = mavg_pkg::WARMUP_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input samples
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] level_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] scaled_level_o,
  output logic [31:0] current_gain_o
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = 16 + IDX_W;
  localparam int TN_W  = 16 + LEN_W;
  localparam int NUM_W = TN_W + 16;

  mavg_pkg::state_e state_q, state_d;

  logic [15:0]      gain_target_q;
  logic [15:0]      level_threshold_q;
  logic [10:0]      history_len_q;
  logic             apb_wr;

  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ring_full_q, ring_full_d;
  logic [31:0]      gain_q, gain_d;

  logic [15:0]      lv_q, lv_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0] n_q, n_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [47:0]      prod_q, prod_d;

  logic             out_valid_q, out_valid_d;
  logic [14:0]      out_scaled_q, out_scaled_d;
  logic [31:0]      out_gain_q, out_gain_d;

  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] slot_now;
  logic [LEN_W-1:0] nxt;
  logic [LEN_W-1:0] idx_new;
  logic             wrap;
  logic             full_new;
  logic [TN_W-1:0]  tn;
  logic [31:0]      prod_hi;

  mavg_pkg::ring_req_t ring_req;
  logic [15:0]         ring_rd;
  mavg_pkg::div_stat_t div_stat;
  logic                div_start;
  logic [31:0]         div_quot;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      mavg_pkg::REG_GAIN_TARGET:     prdata = 32'(gain_target_q);
      mavg_pkg::REG_LEVEL_THRESHOLD: prdata = 32'(level_threshold_q);
      mavg_pkg::REG_HISTORY_LEN:     prdata = 32'(history_len_q);
      default:                       prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_target_q     <= mavg_pkg::GAIN_TARGET_RST;
      level_threshold_q <= mavg_pkg::LEVEL_THRESHOLD_RST;
      history_len_q     <= mavg_pkg::HISTORY_LEN_RST;
    end else if (apb_wr) begin
      case (paddr[3:2])
        mavg_pkg::REG_GAIN_TARGET:     gain_target_q     <= pwdata[15:0];
        mavg_pkg::REG_LEVEL_THRESHOLD: level_threshold_q <= pwdata[15:0];
        mavg_pkg::REG_HISTORY_LEN:     history_len_q     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  // zero length acts as one, anything past the memory as the full depth
  always_comb begin
    if (history_len_q == 11'd0) begin
      eff_len = LEN_W'(1);
    end else if (32'(history_len_q) > 32'(HISTORY_DEPTH)) begin
      eff_len = LEN_W'(HISTORY_DEPTH);
    end else begin
      eff_len = LEN_W'(history_len_q);
    end
  end

  assign slot_now = (LEN_W'(wr_idx_q) >= eff_len) ? '0 : wr_idx_q;
  assign nxt      = LEN_W'(slot_q) + LEN_W'(1);
  assign wrap     = nxt >= eff_len;
  assign idx_new  = wrap ? '0 : nxt;
  assign full_new = ring_full_q || wrap;
  assign tn       = TN_W'(gain_target_q) * TN_W'(n_q);
  assign prod_hi  = prod_q[47:16];

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    sum_d        = sum_q;
    ring_full_d  = ring_full_q;
    gain_d       = gain_q;
    lv_d         = lv_q;
    slot_d       = slot_q;
    n_d          = n_q;
    num_d        = num_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q;
    out_scaled_d = out_scaled_q;
    out_gain_d   = out_gain_q;
    ring_req     = '0;
    div_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mavg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          lv_d = level_i;
          if (level_i >= level_threshold_q) begin
            ring_req.rd_en = 1'b1;
            ring_req.addr  = mavg_pkg::RING_AW_MAX'(slot_now);
            slot_d         = slot_now;
            state_d        = mavg_pkg::ST_RING;
          end else begin
            state_d = mavg_pkg::ST_MUL;
          end
        end
      end
      mavg_pkg::ST_RING: begin
        // old entry is back from memory: swap it out of the sum and overwrite
        sum_d            = sum_q - SUM_W'(ring_rd) + SUM_W'(lv_q);
        ring_req.wr_en   = 1'b1;
        ring_req.addr    = mavg_pkg::RING_AW_MAX'(slot_q);
        ring_req.wr_data = lv_q;
        wr_idx_d         = IDX_W'(idx_new);
        ring_full_d      = full_new;
        n_d              = full_new ? eff_len : idx_new;
        if (full_new || (32'(idx_new) > 32'(WARMUP_COUNT))) begin
          state_d = mavg_pkg::ST_NUM;
        end else begin
          state_d = mavg_pkg::ST_MUL;
        end
      end
      mavg_pkg::ST_NUM: begin
        num_d = {tn, 16'h0000};
        if (sum_q == '0) begin
          gain_d  = 32'hFFFF_FFFF;
          state_d = mavg_pkg::ST_MUL;
        end else begin
          state_d = mavg_pkg::ST_DIV_GO;
        end
      end
      mavg_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = mavg_pkg::ST_DIV_WAIT;
      end
      mavg_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          gain_d  = div_quot;
          state_d = mavg_pkg::ST_MUL;
        end
      end
      mavg_pkg::ST_MUL: begin
        prod_d  = 48'(lv_q) * 48'(gain_q);
        state_d = mavg_pkg::ST_OUT;
      end
      mavg_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_scaled_d = (prod_hi > 32'(mavg_pkg::OUT_CLAMP)) ? mavg_pkg::OUT_CLAMP
                                                               : prod_hi[14:0];
          out_gain_d   = gain_q;
          state_d      = mavg_pkg::ST_IDLE;
        end
      end
      default: state_d = mavg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mavg_pkg::ST_IDLE;
      wr_idx_q    <= '0;
      sum_q       <= '0;
      ring_full_q <= 1'b0;
      gain_q      <= mavg_pkg::GAIN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      sum_q       <= sum_d;
      ring_full_q <= ring_full_d;
      gain_q      <= gain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lv_q         <= lv_d;
    slot_q       <= slot_d;
    n_q          <= n_d;
    num_q        <= num_d;
    prod_q       <= prod_d;
    out_scaled_q <= out_scaled_d;
    out_gain_q   <= out_gain_d;
  end

  assign in_ready_o     = state_q == mavg_pkg::ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign scaled_level_o = out_scaled_q;
  assign current_gain_o = out_gain_q;

  // ---------------------------------------------------------------- units
  mavg_ring #(
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_rd)
  );

  mavg_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (sum_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  `MAGC_ASSERT(a_full_sticky, clk_i, rst_ni, ring_full_q |=> ring_full_q, "ring full flag dropped")
  `MAGC_ASSERT_IMPL(a_div_idle, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `MAGC_ASSERT_IMPL(a_div_done, clk_i, rst_ni, div_stat.done, state_q == mavg_pkg::ST_DIV_WAIT, "quotient with nobody waiting")

endmodule

FILE: rtl/mavg_ring.sv
// ----------------------------------------------------------------------------
// mavg_ring
// Sample history memory, registered read, with a high-water mark
// so that never-written entries read as zero without a clearing pass.
// ----------------------------------------------------------------------------
`include "moving_average_auto_gain_core_assert.svh"

module mavg_ring #(
  parameter int DEPTH = mavg_pkg::HISTORY_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mavg_pkg::ring_req_t req_i,
  output logic [15:0]         rd_data_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);

  logic [15:0]      mem [DEPTH];
  logic [15:0]      rd_q;
  logic             rd_valid_q;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [AW-1:0]    addr;

  assign addr = req_i.addr[AW-1:0];

  // writes land below or at the mark, never beyond it, so the written set is a prefix
  always_comb begin
    fill_d = fill_q;
    if (req_i.wr_en && (LEN_W'(addr) >= fill_q)) begin
      fill_d = LEN_W'(addr) + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (req_i.rd_en) begin
        rd_valid_q <= LEN_W'(addr) < fill_q;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : 16'h0000;

  `MAGC_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= LEN_W'(DEPTH), "fill mark beyond depth")
  `MAGC_ASSERT_IMPL(a_rw_excl, clk_i, rst_ni, req_i.wr_en, !req_i.rd_en, "ring read and write together")
  `MAGC_ASSERT_IMPL(a_prefix, clk_i, rst_ni, req_i.wr_en, LEN_W'(addr) <= fill_q, "ring write leaves a gap")

endmodule

FILE: rtl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Radix-2 restoring divider, one quotient bit per cycle, result saturated
// to 32 bits.
// ----------------------------------------------------------------------------
module mavg_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output mavg_pkg::div_stat_t stat_o,
  output logic [31:0]         quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // quotient bits shift into the numerator register as it drains
  assign rem_sh = {rem_q, acc_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      acc_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      acc_d = {acc_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = (|acc_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : acc_q[31:0];

endmodule
